// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the sketch RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check prop at every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/cucm_pkg.sv
// ----------------------------------------------------------------------------
// cucm_pkg
// Shared constants and types of the conservative-update count-min sketch.
// ----------------------------------------------------------------------------
package cucm_pkg;

    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 4096;
    localparam int MAX_ROWS = 4;
    localparam int COL_W    = 12;
    localparam int CNT_W    = 16;
    localparam int DATA_W   = MAX_ROWS * COL_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic
    {
        KIND_INSERT,
        KIND_QUERY
    } kind_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_QUOT,
        S_REM,
        S_READ,
        S_MIN,
        S_UPD
    } state_t;

    typedef struct packed
    {
        logic             load;
        logic             clr;
        logic             upd;
        logic [CNT_W-1:0] min;
    } lane_ctl_t;

endpackage

// File: rtl/cucm_lane.sv
// ----------------------------------------------------------------------------
// cucm_lane
// One sketch row: column reduction, counter bank, conditional increment.
// ----------------------------------------------------------------------------
module cucm_lane #(
    parameter  int COLS  = cucm_pkg::COLS_DEF,
    localparam int IDX_W = $clog2(COLS)
) (
    input  logic                     clk,
    input  logic [cucm_pkg::COL_W-1:0] col,
    input  cucm_pkg::lane_ctl_t      ctl,
    input  logic [IDX_W-1:0]         clr_addr,
    output logic [cucm_pkg::CNT_W-1:0] value
);
    import cucm_pkg::*;

    localparam int RECIP = (1 << 24) / COLS;
    localparam logic [23:0] RECIP_V = 24'(RECIP);
    localparam logic [16:0] COLS_V  = 17'(COLS);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] q_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] rd_reg;
    logic [CNT_W-1:0] bank [COLS];

    logic [35:0]      prod;
    logic [28:0]      qc;
    logic [16:0]      diff;
    logic [16:0]      rem;
    logic             hit;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;

    assign prod  = {24'b0, col_reg} * {12'b0, RECIP_V};
    assign qc    = {17'b0, q_reg} * {12'b0, COLS_V};
    assign diff  = {5'b0, col_reg} - qc[16:0];
    assign rem   = (diff >= COLS_V) ? (diff - COLS_V) : diff;
    assign hit   = ctl.upd && (rd_reg == ctl.min) && (ctl.min != CNT_MAX);
    assign we    = ctl.clr || hit;
    assign waddr = ctl.clr ? clr_addr : idx_reg;
    assign wdata = ctl.clr ? '0 : rd_reg + CNT_W'(1);
    assign value = rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            col_reg <= col;
        end
        q_reg   <= prod[35:24];
        idx_reg <= rem[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bank[waddr] <= wdata;
        end
        rd_reg <= bank[idx_reg];
    end

endmodule

// File: rtl/cucm_merge.sv
// ----------------------------------------------------------------------------
// cucm_merge
// Registered minimum over the counters read by all lanes.
// ----------------------------------------------------------------------------
module cucm_merge #(
    parameter int ROWS = cucm_pkg::ROWS_DEF
) (
    input  logic                                clk,
    input  logic [ROWS-1:0][cucm_pkg::CNT_W-1:0] values,
    output logic [cucm_pkg::CNT_W-1:0]          min
);
    import cucm_pkg::*;

    logic [CNT_W-1:0] min_reg;
    logic [CNT_W-1:0] min_next;

    always_comb
    begin
        min_next = CNT_MAX;
        for (int r = 0; r < ROWS; r++)
        begin
            if (values[r] < min_next)
            begin
                min_next = values[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
    end

    assign min = min_reg;

endmodule

// File: rtl/conservative_update_count_min.sv
// Flow: an accepted request passes the two-step column reduction multiplies,
// the registered bank read and the min merge; a query then waits for a free
// output. A new request is taken only in idle, once the last one is done.
// Reset: asynchronous, active low; then a clearing pass over every column
// address zeroes every bank in parallel while s_tready stays low.
// ----------------------------------------------------------------------------
// conservative_update_count_min
// Count-min sketch with conservative update, one bank per row.
// ----------------------------------------------------------------------------
module conservative_update_count_min #(
    parameter int ROWS = cucm_pkg::ROWS_DEF,
    parameter int COLS = cucm_pkg::COLS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cucm_pkg::DATA_W-1:0] s_tdata,  // col_row0, col_row1, col_row2, col_row3
    input  logic                        s_tuser,  // kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cucm_pkg::CNT_W-1:0]  m_tdata   // estimate
);
    import cucm_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(COLS);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(COLS - 1);

    state_t                     state_reg;
    state_t                     state_next;
    kind_t                      kind_reg;
    logic [IDX_W-1:0]           clr_addr_reg;
    logic [IDX_W-1:0]           clr_addr_next;
    logic                       m_tvalid_reg;
    logic                       m_tvalid_next;
    logic [CNT_W-1:0]           m_tdata_reg;
    logic                       accept;
    logic                       out_free;
    logic                       emit;
    lane_ctl_t                  ctl;
    logic [ROWS-1:0][CNT_W-1:0] values;
    logic [CNT_W-1:0]           min;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        s_tready      = 1'b0;
        emit          = 1'b0;
        ctl.load      = 1'b0;
        ctl.clr       = 1'b0;
        ctl.upd       = 1'b0;
        ctl.min       = min;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr       = 1'b1;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                ctl.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT: state_next = S_REM;
            S_REM:  state_next = S_READ;
            S_READ: state_next = S_MIN;
            S_MIN:  state_next = S_UPD;
            S_UPD:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    ctl.upd    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_t'(s_tuser);
        end
        if (emit)
        begin
            m_tdata_reg <= min;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    for (genvar r = 0; r < ROWS; r++)
    begin : g_lane
        cucm_lane #(
            .COLS (COLS)
        ) u_lane (
            .clk      (clk),
            .col      (s_tdata[r*COL_W +: COL_W]),
            .ctl      (ctl),
            .clr_addr (clr_addr_reg),
            .value    (values[r])
        );
    end

    cucm_merge #(
        .ROWS (ROWS)
    ) u_merge (
        .clk    (clk),
        .values (values),
        .min    (min)
    );

    `ASSERT_CLK(a_emit_from_query, $rose(m_tvalid) |-> $past(state_reg == S_UPD && kind_reg == KIND_QUERY), "result raised without a query in update")
    `ASSERT_CLK(a_clear_sweep, (state_reg == S_CLEAR && clr_addr_reg != LAST_ADDR) |=> (state_reg == S_CLEAR && clr_addr_reg == $past(clr_addr_reg) + IDX_W'(1)), "clearing pass skipped an entry")
    `ASSERT_CLK(a_min_bound, (state_reg == S_UPD) |-> (min <= values[0]), "merged minimum above lane zero counter")

endmodule
